/* rtl/date_period_overlap_days_macros.svh */
// ----------------------------------------------------------------------------
// date_period_overlap_days_macros.svh
// Assertion macros shared by the date period overlap block.
// ----------------------------------------------------------------------------
`ifndef DATE_PERIOD_OVERLAP_DAYS_MACROS_SVH
`define DATE_PERIOD_OVERLAP_DAYS_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define DPOD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dpod assertion failed");

// consequent holds in the cycle after the antecedent
`define DPOD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dpod assertion failed");

`endif

/* rtl/dpod_pkg.sv */
// ----------------------------------------------------------------------------
// dpod_pkg
// Types, constants and calendar tables for the date period overlap block.
// ----------------------------------------------------------------------------
package dpod_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int DAYNUM_W = 22;

   localparam logic [YEAR_W-1:0] YEAR_MAX  = 14'd9999;
   localparam logic [14:0]       YEAR_BIAS = 15'd400;
   localparam logic [23:0]       DAYS_PER_YEAR = 24'd365;

   // floor(x / 100) == (x * 5243) >> 19 for x below 43699
   localparam logic [27:0] DIV100_MUL = 28'd5243;
   localparam int          DIV100_SHIFT = 19;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_REVERSED = 2'd1,
      STATUS_BAD_DATE = 2'd2
   } status_type;

   // days in a month; 0 for a month code that means nothing
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days from March 1 to the first of the month, year counted from March
   function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [8:0] ofs;
      unique case (m)
         4'd3:    ofs = 9'd0;
         4'd4:    ofs = 9'd31;
         4'd5:    ofs = 9'd61;
         4'd6:    ofs = 9'd92;
         4'd7:    ofs = 9'd122;
         4'd8:    ofs = 9'd153;
         4'd9:    ofs = 9'd184;
         4'd10:   ofs = 9'd214;
         4'd11:   ofs = 9'd245;
         4'd12:   ofs = 9'd275;
         4'd1:    ofs = 9'd306;
         4'd2:    ofs = 9'd337;
         default: ofs = 9'd0;
      endcase
      return ofs;
   endfunction

endpackage

/* rtl/dpod_req_if.sv */
// ----------------------------------------------------------------------------
// dpod_req_if
// Request channel: two date periods per word.
// ----------------------------------------------------------------------------
interface dpod_req_if;
   logic        valid;
   logic        ready;
   logic [13:0] p1_start_year;
   logic [3:0]  p1_start_month;
   logic [4:0]  p1_start_day;
   logic [13:0] p1_end_year;
   logic [3:0]  p1_end_month;
   logic [4:0]  p1_end_day;
   logic [13:0] p2_start_year;
   logic [3:0]  p2_start_month;
   logic [4:0]  p2_start_day;
   logic [13:0] p2_end_year;
   logic [3:0]  p2_end_month;
   logic [4:0]  p2_end_day;

   modport source (
      output valid,
      input  ready,
      output p1_start_year, p1_start_month, p1_start_day,
      output p1_end_year, p1_end_month, p1_end_day,
      output p2_start_year, p2_start_month, p2_start_day,
      output p2_end_year, p2_end_month, p2_end_day
   );

   modport sink (
      input  valid,
      output ready,
      input  p1_start_year, p1_start_month, p1_start_day,
      input  p1_end_year, p1_end_month, p1_end_day,
      input  p2_start_year, p2_start_month, p2_start_day,
      input  p2_end_year, p2_end_month, p2_end_day
   );
endinterface

/* rtl/dpod_rsp_if.sv */
// ----------------------------------------------------------------------------
// dpod_rsp_if
// Response channel: overlap day count and status per word.
// ----------------------------------------------------------------------------
interface dpod_rsp_if;
   logic        valid;
   logic        ready;
   logic [21:0] overlap_days;
   logic [1:0]  status;

   modport source (
      output valid,
      input  ready,
      output overlap_days, status
   );

   modport sink (
      input  valid,
      output ready,
      input  overlap_days, status
   );
endinterface

/* rtl/dpod_day_num.sv */
// ----------------------------------------------------------------------------
// dpod_day_num
// Checks one Gregorian date and converts it to a linear day number.
// ----------------------------------------------------------------------------
module dpod_day_num
   import dpod_pkg::*;
(
   input  date_type              date,
   output logic [DAYNUM_W-1:0]   day_num,
   output logic                  date_ok
);

   logic [27:0] y_prod;
   logic [7:0]  y_cent;
   logic [13:0] y_rem_full;
   logic [6:0]  y_rem;
   logic        leap;
   logic [14:0] yy;
   logic [27:0] yy_prod;
   logic [7:0]  yy_cent;
   logic [23:0] dn_sum;

   // leap year test: century and remainder from a reciprocal multiply
   assign y_prod     = {14'b0, date.year} * DIV100_MUL;
   assign y_cent     = y_prod[DIV100_SHIFT +: 8];
   assign y_rem_full = date.year - 14'({6'b0, y_cent} * 14'd100);
   assign y_rem      = y_rem_full[6:0];
   assign leap       = (y_rem == 7'd0) ? (y_cent[1:0] == 2'b00)
                                       : (date.year[1:0] == 2'b00);

   assign date_ok = (date.year <= YEAR_MAX) && (date.month >= 4'd1) &&
                    (date.month <= 4'd12) && (date.day != 5'd0) &&
                    (date.day <= month_length(date.month, leap));

   // year starts in March, so Jan and Feb belong to the previous year
   assign yy      = {1'b0, date.year} + YEAR_BIAS - ((date.month <= 4'd2) ? 15'd1 : 15'd0);
   assign yy_prod = {13'b0, yy} * DIV100_MUL;
   assign yy_cent = yy_prod[DIV100_SHIFT +: 8];

   assign dn_sum = {9'b0, yy} * DAYS_PER_YEAR
                 + {11'b0, yy[14:2]}
                 - {16'b0, yy_cent}
                 + {18'b0, yy_cent[7:2]}
                 + {15'b0, month_offset(date.month)}
                 + {19'b0, date.day}
                 - 24'd1;

   assign day_num = dn_sum[DAYNUM_W-1:0];

endmodule

/* rtl/date_period_overlap_days.sv */
// A word passes the input register, day number register and response register.
// Throughput: one word per cycle while rsp_ch.ready is not held low; each register
// advances whenever the stage after it is free.
// Reset (synchronous, active high) empties all three stages; payload is not cleared.
// ----------------------------------------------------------------------------
// date_period_overlap_days
// Counts the days shared by two inclusive Gregorian date periods.
// ----------------------------------------------------------------------------
module date_period_overlap_days
   import dpod_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   dpod_req_if.sink       req_ch,
   dpod_rsp_if.source     rsp_ch
);

   // stage valids
   logic a_vld_ff, a_vld_in;
   logic b_vld_ff, b_vld_in;
   logic o_vld_ff, o_vld_in;
   logic a_free, b_free, o_free;

   // payload
   date_type              a_date_ff [4];
   date_type              a_date_in [4];
   logic [DAYNUM_W-1:0]   dn        [4];
   logic                  dn_ok     [4];
   logic [DAYNUM_W-1:0]   b_dn_ff   [4];
   logic [DAYNUM_W-1:0]   b_dn_in   [4];
   logic                  b_bad_ff, b_bad_in;
   logic [DAYNUM_W-1:0]   o_count_ff, o_count_in;
   status_type            o_status_ff, o_status_in;

   logic                  reversed;
   logic [DAYNUM_W-1:0]   lo, hi;

   assign o_free = !o_vld_ff || rsp_ch.ready;
   assign b_free = !b_vld_ff || o_free;
   assign a_free = !a_vld_ff || b_free;

   assign req_ch.ready = a_free;

   assign a_vld_in = a_free ? req_ch.valid : a_vld_ff;
   assign b_vld_in = b_free ? a_vld_ff : b_vld_ff;
   assign o_vld_in = o_free ? b_vld_ff : o_vld_ff;

   always_comb begin
      a_date_in = a_date_ff;
      if (a_free && req_ch.valid) begin
         a_date_in[0] = '{req_ch.p1_start_year, req_ch.p1_start_month, req_ch.p1_start_day};
         a_date_in[1] = '{req_ch.p1_end_year,   req_ch.p1_end_month,   req_ch.p1_end_day};
         a_date_in[2] = '{req_ch.p2_start_year, req_ch.p2_start_month, req_ch.p2_start_day};
         a_date_in[3] = '{req_ch.p2_end_year,   req_ch.p2_end_month,   req_ch.p2_end_day};
      end
   end

   for (genvar gi = 0; gi < 4; gi++) begin : g_dn
      dpod_day_num u_day_num (
         .date    (a_date_ff[gi]),
         .day_num (dn[gi]),
         .date_ok (dn_ok[gi])
      );
   end

   always_comb begin
      b_dn_in  = b_dn_ff;
      b_bad_in = b_bad_ff;
      if (b_free && a_vld_ff) begin
         b_dn_in  = dn;
         b_bad_in = !(dn_ok[0] && dn_ok[1] && dn_ok[2] && dn_ok[3]);
      end
   end

   // overlap is min(end) - max(start) + 1 when not negative
   assign reversed = (b_dn_ff[1] < b_dn_ff[0]) || (b_dn_ff[3] < b_dn_ff[2]);
   assign lo       = (b_dn_ff[0] > b_dn_ff[2]) ? b_dn_ff[0] : b_dn_ff[2];
   assign hi       = (b_dn_ff[1] < b_dn_ff[3]) ? b_dn_ff[1] : b_dn_ff[3];

   always_comb begin
      o_count_in  = o_count_ff;
      o_status_in = o_status_ff;
      if (o_free && b_vld_ff) begin
         priority if (b_bad_ff) begin
            o_status_in = STATUS_BAD_DATE;
            o_count_in  = '0;
         end else if (reversed) begin
            o_status_in = STATUS_REVERSED;
            o_count_in  = '0;
         end else if (hi >= lo) begin
            o_status_in = STATUS_OK;
            o_count_in  = hi - lo + 22'd1;
         end else begin
            o_status_in = STATUS_OK;
            o_count_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         o_vld_ff <= o_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      a_date_ff   <= a_date_in;
      b_dn_ff     <= b_dn_in;
      b_bad_ff    <= b_bad_in;
      o_count_ff  <= o_count_in;
      o_status_ff <= o_status_in;
   end

   assign rsp_ch.valid        = o_vld_ff;
   assign rsp_ch.overlap_days = o_count_ff;
   assign rsp_ch.status       = o_status_ff;

`include "date_period_overlap_days_macros.svh"

   `DPOD_ASSERT_NOW(a_no_count_on_fault, clock, reset, o_vld_ff && (o_status_ff != STATUS_OK), o_count_ff == '0)
   `DPOD_ASSERT_NEXT(a_accept_loads, clock, reset, req_ch.valid && req_ch.ready, a_vld_ff)
   `DPOD_ASSERT_NEXT(a_mid_advances, clock, reset, b_vld_ff && o_free, o_vld_ff)

endmodule

/* tb/tb_date_period_overlap_days.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_date_period_overlap_days
// Self-checking bench for the date period overlap counter. A scoreboard
// predicts the shared day count and status of every accepted request word
// and compares it field by field with the responses, in order. Stimulus runs
// calendar corners first, then random period pairs under three idle mixes,
// with a long response stall and drain pauses in between.
// ----------------------------------------------------------------------------
module tb_date_period_overlap_days
   import dpod_pkg::*;
();

   typedef struct packed {
      date_type p1_start;
      date_type p1_end;
      date_type p2_start;
      date_type p2_end;
   } request_type;

   typedef struct {
      logic [21:0] days;
      status_type  status;
   } overlap_result_type;

   class overlap_scoreboard_type;
      overlap_result_type expected_overlaps[$];
      int unsigned     month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      int unsigned     mismatches = 0;
      int unsigned     noted = 0;
      int unsigned     checked = 0;
      int unsigned     with_overlap = 0;
      int unsigned     disjoint = 0;
      int unsigned     reversed = 0;
      int unsigned     bad_date = 0;

      function bit leap_year(int unsigned y);
         return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
      endfunction

      // 0 for a month code that means nothing
      function int unsigned month_limit(int unsigned y, int unsigned m);
         if (m < 1 || m > 12) return 0;
         if (m == 2) return leap_year(y) ? 29 : 28;
         return month_days[m-1];
      endfunction

      function bit date_ok(date_type d);
         if (d.year > 9999 || d.day == 0) return 0;
         return d.day <= month_limit(d.year, d.month);
      endfunction

      // days since a March-based epoch 400 years before year 0
      function int unsigned day_index(date_type d);
         int unsigned yy;
         int unsigned mp;
         yy = d.year + 400 - ((d.month <= 2) ? 1 : 0);
         mp = (d.month + 9) % 12;
         return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + d.day - 1;
      endfunction

      function overlap_result_type predict_overlap(request_type r);
         date_type           dt[4];
         int unsigned        idx[4];
         int unsigned        lo;
         int unsigned        hi;
         overlap_result_type res;
         dt[0] = r.p1_start;
         dt[1] = r.p1_end;
         dt[2] = r.p2_start;
         dt[3] = r.p2_end;
         res.days   = '0;
         res.status = STATUS_OK;
         foreach (dt[i])
            if (!date_ok(dt[i])) res.status = STATUS_BAD_DATE;
         if (res.status == STATUS_OK) begin
            foreach (dt[i]) idx[i] = day_index(dt[i]);
            if (idx[1] < idx[0] || idx[3] < idx[2]) begin
               res.status = STATUS_REVERSED;
            end else begin
               lo = (idx[0] > idx[2]) ? idx[0] : idx[2];
               hi = (idx[1] < idx[3]) ? idx[1] : idx[3];
               if (hi >= lo) res.days = 22'(hi - lo + 1);
            end
         end
         return res;
      endfunction

      function void note_request(request_type r);
         expected_overlaps.push_back(predict_overlap(r));
         noted++;
      endfunction

      function int pending();
         return expected_overlaps.size();
      endfunction

      task report_mismatch(string msg);
         if (mismatches < 30) $display("ERROR @%0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_response(logic [21:0] days, logic [1:0] st);
         overlap_result_type want;
         if (expected_overlaps.size() == 0) begin
            report_mismatch($sformatf("unexpected response days=%0d status=%0d", days, st));
         end else begin
            want = expected_overlaps.pop_front();
            checked++;
            if (st !== want.status)
               report_mismatch($sformatf("word %0d: status %0d, want %0d",
                                         checked, st, want.status));
            if (days !== want.days)
               report_mismatch($sformatf("word %0d: overlap_days %0d, want %0d",
                                         checked, days, want.days));
            case (want.status)
               STATUS_REVERSED: reversed++;
               STATUS_BAD_DATE: bad_date++;
               default: begin
                  if (want.days != 0) with_overlap++;
                  else disjoint++;
               end
            endcase
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   dpod_req_if req_bus ();
   dpod_rsp_if rsp_bus ();

   date_period_overlap_days dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   overlap_scoreboard_type sb = new();

   int unsigned send_idle_pct = 7;
   int unsigned recv_idle_pct = 72;
   int unsigned hold_left = 0;
   int unsigned directed_count;

   always #5 clock = ~clock;

   // receiver: random back-pressure, plus a counted hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_response(rsp_bus.overlap_days, rsp_bus.status);
   end

   initial begin
      #2ms;
      $display("Timeout with %0d responses outstanding", sb.pending());
      $display("FAIL");
      $finish;
   end

   function automatic date_type mk_date(int unsigned y, int unsigned m, int unsigned d);
      date_type t;
      t.year  = 14'(y);
      t.month = 4'(m);
      t.day   = 5'(d);
      return t;
   endfunction

   function automatic request_type mk_req(date_type a, date_type b, date_type c, date_type e);
      request_type r;
      r.p1_start = a;
      r.p1_end   = b;
      r.p2_start = c;
      r.p2_end   = e;
      return r;
   endfunction

   function automatic date_type rand_date(int unsigned y_lo, int unsigned y_hi);
      date_type    d;
      int unsigned lim;
      int unsigned pick;
      d.year  = 14'($urandom_range(y_hi, y_lo));
      d.month = 4'($urandom_range(12, 1));
      lim  = sb.month_limit(d.year, d.month);
      pick = $urandom_range(9);
      if (pick == 0) d.day = 5'd1;
      else if (pick == 1) d.day = 5'(lim);
      else d.day = 5'($urandom_range(lim, 1));
      return d;
   endfunction

   // two ordered periods near a common year, so overlaps are frequent
   function automatic request_type well_formed_request();
      request_type r;
      date_type    tmp;
      int unsigned base;
      int unsigned spread;
      int unsigned y_lo;
      int unsigned y_hi;
      if ($urandom_range(9) == 0) base = $urandom_range(1) ? 9999 : 0;
      else base = $urandom_range(9999);
      case ($urandom_range(5))
         0, 1:    spread = 0;
         2:       spread = 1;
         3:       spread = 4;
         4:       spread = 60;
         default: spread = 10000;
      endcase
      y_lo = (base > spread) ? base - spread : 0;
      y_hi = (base + spread > 9999) ? 9999 : base + spread;
      r.p1_start = rand_date(y_lo, y_hi);
      r.p1_end   = rand_date(y_lo, y_hi);
      r.p2_start = rand_date(y_lo, y_hi);
      r.p2_end   = rand_date(y_lo, y_hi);
      if (sb.day_index(r.p1_start) > sb.day_index(r.p1_end)) begin
         tmp = r.p1_start; r.p1_start = r.p1_end; r.p1_end = tmp;
      end
      if (sb.day_index(r.p2_start) > sb.day_index(r.p2_end)) begin
         tmp = r.p2_start; r.p2_start = r.p2_end; r.p2_end = tmp;
      end
      return r;
   endfunction

   function automatic date_type break_date(date_type d);
      int unsigned lim;
      case ($urandom_range(4))
         0: d.month = 4'd0;
         1: d.month = 4'($urandom_range(15, 13));
         2: d.day = 5'd0;
         3: begin
            lim = sb.month_limit(d.year, d.month);
            if (lim < 31) d.day = 5'($urandom_range(31, lim + 1));
            else d.day = 5'd0;
         end
         default: d.year = 14'($urandom_range(16383, 10000));
      endcase
      return d;
   endfunction

   function automatic request_type random_request();
      request_type  r;
      date_type     tmp;
      logic [127:0] raw;
      int unsigned  pick;
      pick = $urandom_range(99);
      r = well_formed_request();
      if (pick >= 90) begin
         raw = {$urandom(), $urandom(), $urandom(), $urandom()};
         r = raw[$bits(request_type)-1:0];
      end else if (pick >= 80) begin
         case ($urandom_range(3))
            0:       r.p1_start = break_date(r.p1_start);
            1:       r.p1_end   = break_date(r.p1_end);
            2:       r.p2_start = break_date(r.p2_start);
            default: r.p2_end   = break_date(r.p2_end);
         endcase
      end else if (pick >= 70) begin
         if ($urandom_range(1)) begin
            tmp = r.p1_start; r.p1_start = r.p1_end; r.p1_end = tmp;
         end else begin
            tmp = r.p2_start; r.p2_start = r.p2_end; r.p2_end = tmp;
         end
      end
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.p1_start_year  <= r.p1_start.year;
      req_bus.p1_start_month <= r.p1_start.month;
      req_bus.p1_start_day   <= r.p1_start.day;
      req_bus.p1_end_year    <= r.p1_end.year;
      req_bus.p1_end_month   <= r.p1_end.month;
      req_bus.p1_end_day     <= r.p1_end.day;
      req_bus.p2_start_year  <= r.p2_start.year;
      req_bus.p2_start_month <= r.p2_start.month;
      req_bus.p2_start_day   <= r.p2_start.day;
      req_bus.p2_end_year    <= r.p2_end.year;
      req_bus.p2_end_month   <= r.p2_end.month;
      req_bus.p2_end_day     <= r.p2_end.day;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic send_random(int unsigned n);
      repeat (n) send_word(random_request());
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic send_directed();
      date_type any_day;
      any_day = mk_date(2020, 6, 15);
      send_word(mk_req(mk_date(0, 1, 1), mk_date(0, 1, 1), mk_date(0, 1, 1), mk_date(0, 1, 1)));
      send_word(mk_req(mk_date(0, 1, 1), mk_date(9999, 12, 31),
                       mk_date(0, 1, 1), mk_date(9999, 12, 31)));
      // adjacent months, no shared day
      send_word(mk_req(mk_date(2020, 1, 1), mk_date(2020, 1, 31),
                       mk_date(2020, 2, 1), mk_date(2020, 2, 29)));
      // periods touch on one day
      send_word(mk_req(mk_date(2020, 1, 1), mk_date(2020, 2, 1),
                       mk_date(2020, 2, 1), mk_date(2020, 3, 1)));
      // second period nested inside the first, across a leap day
      send_word(mk_req(mk_date(1999, 12, 31), mk_date(2001, 1, 1),
                       mk_date(2000, 2, 28), mk_date(2000, 3, 1)));
      // second period wholly before the first
      send_word(mk_req(mk_date(9999, 12, 31), mk_date(9999, 12, 31),
                       mk_date(0, 1, 1), mk_date(0, 3, 1)));
      // leap days in 400-year and 4-year leap years
      send_word(mk_req(mk_date(2000, 2, 29), mk_date(2024, 2, 29),
                       mk_date(1600, 2, 29), mk_date(2000, 3, 1)));
      // Feb 29 in century and common years
      send_word(mk_req(mk_date(1900, 2, 29), any_day, any_day, any_day));
      send_word(mk_req(any_day, any_day, any_day, mk_date(2100, 2, 29)));
      send_word(mk_req(any_day, mk_date(2023, 2, 29), any_day, any_day));
      // month and day codes out of range
      send_word(mk_req(mk_date(2020, 0, 1), any_day, any_day, any_day));
      send_word(mk_req(any_day, any_day, mk_date(2020, 13, 1), any_day));
      send_word(mk_req(any_day, any_day, any_day, mk_date(2020, 15, 10)));
      send_word(mk_req(any_day, mk_date(2020, 5, 0), any_day, any_day));
      send_word(mk_req(any_day, any_day, mk_date(2020, 4, 31), mk_date(2020, 12, 31)));
      // years beyond 9999
      send_word(mk_req(mk_date(10000, 1, 1), any_day, any_day, any_day));
      send_word(mk_req(any_day, any_day, any_day, mk_date(16383, 12, 31)));
      // reversed periods, one overlapping and one not
      send_word(mk_req(mk_date(2000, 1, 1), mk_date(1999, 12, 31),
                       mk_date(1999, 1, 1), mk_date(2001, 1, 1)));
      send_word(mk_req(mk_date(100, 1, 1), mk_date(200, 1, 1),
                       mk_date(5000, 3, 1), mk_date(5000, 2, 28)));
      // reversed and impossible together: bad date wins
      send_word(mk_req(mk_date(2000, 1, 1), mk_date(1999, 12, 31),
                       mk_date(2019, 2, 29), any_day));
      send_word(mk_req(mk_date(16383, 15, 31), mk_date(16383, 15, 31),
                       mk_date(16383, 15, 31), mk_date(16383, 15, 31)));
   endtask

   initial begin
      req_bus.valid          = 1'b0;
      req_bus.p1_start_year  = '0;
      req_bus.p1_start_month = '0;
      req_bus.p1_start_day   = '0;
      req_bus.p1_end_year    = '0;
      req_bus.p1_end_month   = '0;
      req_bus.p1_end_day     = '0;
      req_bus.p2_start_year  = '0;
      req_bus.p2_start_month = '0;
      req_bus.p2_start_day   = '0;
      req_bus.p2_end_year    = '0;
      req_bus.p2_end_month   = '0;
      req_bus.p2_end_day     = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_directed();
      directed_count = sb.noted;
      send_random(200);
      drain();

      send_idle_pct = 72;
      recv_idle_pct = 7;
      send_random(200);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // long output stall while words keep coming, so the pipe backs up
      hold_left = 200;
      send_random(40);
      drain();
      send_random(160);
      drain();

      repeat (10) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending()));
      $display("Checked %0d of %0d words (%0d directed): %0d shared days, %0d disjoint,",
               sb.checked, sb.noted, directed_count, sb.with_overlap, sb.disjoint);
      $display("%0d reversed, %0d bad date; three idle mixes and a 200-cycle output stall",
               sb.reversed, sb.bad_date);
      if (sb.mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
